/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the small integer number encoder.
// Each macro takes a label, a property body and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, suspended while reset is asserted.
`define SIE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define SIE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/sie_pkg.sv */
// Shared types, constants and a function of the small integer number encoder.
// No dependencies; used by sie_digit, small_integer_number_encoder, sie_checker and tb_top.
package sie_pkg;

    localparam int unsigned VALUE_W    = 17;
    localparam int unsigned MAG_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned POS_W      = 3;
    localparam int unsigned NUM_DIGITS = 5;
    localparam int unsigned RADIX      = 10;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'd14;
    localparam logic [BYTE_W-1:0] SIGN_NEG    = 8'hFF;
    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

    // The most negative input cannot be shown and is replaced by -65535.
    localparam logic [VALUE_W-1:0] VALUE_MOST_NEG = 17'h10000;
    localparam logic [VALUE_W-1:0] VALUE_CLAMPED  = 17'h10001;

    typedef enum logic [7:0] {
        P_SIGN  = 8'b0000_0001,
        P_DIGIT = 8'b0000_0010,
        P_MARK  = 8'b0000_0100,
        P_ZERO  = 8'b0000_1000,
        P_SGN   = 8'b0001_0000,
        P_LO    = 8'b0010_0000,
        P_HI    = 8'b0100_0000,
        P_END   = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [MAG_W-1:0]   rem;
    } t_digit;

    // Weight of a decimal digit value at a given position: mult * 10^pos.
    function automatic logic [VALUE_W-1:0] digit_weight(input logic [POS_W-1:0] pos,
                                                        input logic [DIGIT_W-1:0] mult);
        logic [VALUE_W-1:0] p;
        case (pos)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            default: p = 17'd0;
        endcase
        return p * {{(VALUE_W-DIGIT_W){1'b0}}, mult};
    endfunction

endpackage

/* hw/rtl/sie_digit.sv */
// One decimal digit step: finds the digit of a remainder at a position and the rest.
// Depends on sie_pkg.
module sie_digit (
    input  logic [sie_pkg::MAG_W-1:0] i_rem,
    input  logic [sie_pkg::POS_W-1:0] i_pos,
    output sie_pkg::t_digit           o_res
);
    import sie_pkg::*;

    logic [VALUE_W-1:0] w [0:RADIX-1];
    logic [VALUE_W-1:0] rem_ext;
    logic [DIGIT_W-1:0] dig;
    logic [VALUE_W-1:0] diff;

    assign rem_ext = {1'b0, i_rem};

    // The compares are independent; the largest multiple not above the
    // remainder gives the digit.
    always_comb begin
        for (int j = 0; j < RADIX; j++) begin
            w[j] = digit_weight(i_pos, DIGIT_W'(j));
        end
        dig = '0;
        for (int j = 1; j < RADIX; j++) begin
            if (rem_ext >= w[j]) begin
                dig = DIGIT_W'(j);
            end
        end
        diff = rem_ext - w[dig];
    end

    assign o_res.digit = dig;
    assign o_res.rem   = diff[MAG_W-1:0];

endmodule

/* hw/rtl/small_integer_number_encoder.sv */
// Small integer number encoder: one signed number in, its tokenized bytes out.
// The byte sequencer steps through a sign step, five digit steps and six tail steps per item.
// A one-item input register takes the next item while the current one is still emitting.
// Results cannot be stalled. Synchronous active-low reset clears all control state.
// Depends on sie_pkg, sie_digit and assert_macros.svh.
`include "assert_macros.svh"

module small_integer_number_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sie_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    output logic [sie_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_last_byte
);
    import sie_pkg::*;

    // Input register.
    logic               r_hold_vld;
    logic [VALUE_W-1:0] r_hold_value;

    // Sequencer state.
    logic               r_act;
    t_phase             r_phase;
    logic               r_seen;
    logic               r_neg;
    logic [MAG_W-1:0]   r_rem;
    logic [MAG_W-1:0]   r_low16;
    logic [POS_W-1:0]   r_pos;

    // Result register.
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_last;

    t_phase             n_phase;
    logic               n_seen;
    logic [MAG_W-1:0]   n_rem;
    logic [POS_W-1:0]   n_pos;
    logic               n_out_valid;
    logic [BYTE_W-1:0]  n_out_byte;
    logic               n_last;

    logic               accept;
    logic               take;
    logic               show;
    logic [VALUE_W-1:0] neg_value;
    logic [MAG_W-1:0]   load_mag;
    t_digit             dres;

    assign take   = r_hold_vld && (!r_act || (r_phase == P_END));
    assign busy   = r_hold_vld && !take;
    assign accept = start && !busy;

    assign neg_value = -r_hold_value;
    assign load_mag  = r_hold_value[VALUE_W-1] ? neg_value[MAG_W-1:0]
                                               : r_hold_value[MAG_W-1:0];

    sie_digit u_digit (
        .i_rem (r_rem),
        .i_pos (r_pos),
        .o_res (dres)
    );

    always_comb begin
        n_phase     = r_phase;
        n_seen      = r_seen;
        n_rem       = r_rem;
        n_pos       = r_pos;
        n_out_valid = 1'b0;
        n_out_byte  = ZERO_BYTE;
        n_last      = 1'b0;
        show        = r_seen || (dres.digit != '0) || (r_pos == '0);
        case (r_phase)
            P_SIGN: begin
                n_out_byte  = ASCII_MINUS;
                n_out_valid = r_neg;
                n_phase     = P_DIGIT;
            end
            P_DIGIT: begin
                // Leading zeros are dropped, but the units digit always shows.
                n_out_byte  = ASCII_ZERO | {{(BYTE_W-DIGIT_W){1'b0}}, dres.digit};
                n_out_valid = show;
                n_seen      = show;
                n_rem       = dres.rem;
                if (r_pos == '0) begin
                    n_phase = P_MARK;
                end else begin
                    n_pos = r_pos - POS_W'(1);
                end
            end
            P_MARK: begin
                n_out_byte  = MARKER_BYTE;
                n_out_valid = 1'b1;
                n_phase     = P_ZERO;
            end
            P_ZERO: begin
                n_out_valid = 1'b1;
                n_phase     = P_SGN;
            end
            P_SGN: begin
                n_out_byte  = r_neg ? SIGN_NEG : ZERO_BYTE;
                n_out_valid = 1'b1;
                n_phase     = P_LO;
            end
            P_LO: begin
                n_out_byte  = r_low16[BYTE_W-1:0];
                n_out_valid = 1'b1;
                n_phase     = P_HI;
            end
            P_HI: begin
                n_out_byte  = r_low16[MAG_W-1:BYTE_W];
                n_out_valid = 1'b1;
                n_phase     = P_END;
            end
            P_END: begin
                n_out_valid = 1'b1;
                n_last      = 1'b1;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
        if (!r_act) begin
            n_out_valid = 1'b0;
            n_last      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld  <= 1'b0;
            r_act       <= 1'b0;
            r_phase     <= P_SIGN;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (accept) begin
                r_hold_vld <= 1'b1;
            end else if (take) begin
                r_hold_vld <= 1'b0;
            end
            if (take) begin
                r_act   <= 1'b1;
                r_phase <= P_SIGN;
                r_seen  <= 1'b0;
            end else begin
                if (r_phase == P_END) begin
                    r_act <= 1'b0;
                end
                r_phase <= n_phase;
                r_seen  <= n_seen;
            end
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hold_value <= (i_value == VALUE_MOST_NEG) ? VALUE_CLAMPED : i_value;
        end
        if (take) begin
            r_neg   <= r_hold_value[VALUE_W-1];
            r_rem   <= load_mag;
            r_low16 <= r_hold_value[MAG_W-1:0];
            r_pos   <= POS_W'(NUM_DIGITS - 1);
        end else begin
            r_rem <= n_rem;
            r_pos <= n_pos;
        end
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_last;

    `SIE_ASSERT(a_last_is_zero,
        o_last_byte |-> (o_out_valid && (o_out_byte == ZERO_BYTE)),
        "last byte must be a strobed zero")
    `SIE_ASSERT(a_no_double_last,
        o_last_byte |=> !o_last_byte,
        "two last bytes in a row")
    `SIE_ASSERT(a_busy_means_held,
        busy |-> r_hold_vld,
        "busy without a held item")
    `SIE_ASSERT(a_digit_before_marker,
        (r_act && (r_phase == P_MARK)) |-> r_seen,
        "marker reached with no digit emitted")

endmodule

/* dv/sie_checker.sv */
`timescale 1ns / 100ps
// Checker for the small integer number encoder: predicts the encoded bytes of each accepted
// number and compares them with the result strobes. Depends on sie_pkg.
module sie_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [sie_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_out_valid,
    input  logic [sie_pkg::BYTE_W-1:0]   i_out_byte,
    input  logic                         i_last_byte,
    output int                           o_mismatch_count,
    output int                           o_bytes_pending
);
    import sie_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] code;
        logic              last;
    } t_token_byte;

    t_token_byte expected_bytes[$];
    int          mismatches = 0;

    function automatic void queue_byte(input logic [BYTE_W-1:0] code, input logic last);
        t_token_byte tb;
        tb.code = code;
        tb.last = last;
        expected_bytes.push_back(tb);
    endfunction

    // Digits with optional minus, the marker, then the five-byte integer form.
    function automatic void encode_number(input logic [VALUE_W-1:0] value);
        int signed         num;
        int unsigned       mag;
        logic [15:0]       low16;
        logic [BYTE_W-1:0] digit_chars[5];
        int                n_digits;
        bit                neg;
        num = $signed(value);
        if (num < -65535) begin
            num = -65535;
        end
        neg = (num < 0);
        mag = neg ? -num : num;
        low16 = num[15:0];
        n_digits = 0;
        do begin
            digit_chars[n_digits] = ASCII_ZERO + BYTE_W'(mag % 10);
            mag = mag / 10;
            n_digits++;
        end while (mag != 0 && n_digits < NUM_DIGITS);
        if (neg) begin
            queue_byte(ASCII_MINUS, 1'b0);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            queue_byte(digit_chars[i], 1'b0);
        end
        queue_byte(MARKER_BYTE, 1'b0);
        queue_byte(ZERO_BYTE, 1'b0);
        queue_byte(neg ? SIGN_NEG : ZERO_BYTE, 1'b0);
        queue_byte(low16[7:0], 1'b0);
        queue_byte(low16[15:8], 1'b0);
        queue_byte(ZERO_BYTE, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_token_byte want;
        if (i_rst_n) begin
            if (i_out_valid) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected byte %h last %b with nothing expected",
                                 $realtime, i_out_byte, i_last_byte);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want.code || i_last_byte !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: byte expected %h last %b, got %h last %b",
                                     $realtime, want.code, want.last, i_out_byte, i_last_byte);
                        end
                    end
                end
            end
            // An item taken at this edge is predicted after the result check above.
            if (i_start && !i_busy) begin
                encode_number(i_value);
            end
        end
        o_mismatch_count <= mismatches;
        o_bytes_pending  <= expected_bytes.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the encoder testbench: clock, reset, number stimulus and the final verdict.
// Depends on sie_pkg, small_integer_number_encoder and sie_checker.
module tb_top;
    import sie_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] i_value;
    logic               o_out_valid;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_last_byte;
    int                 mismatch_count;
    int                 bytes_pending;
    int                 cycle_count = 0;
    int                 item_idx;

    small_integer_number_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    sie_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_value          (i_value),
        .i_out_valid      (o_out_valid),
        .i_out_byte       (o_out_byte),
        .i_last_byte      (o_last_byte),
        .o_mismatch_count (mismatch_count),
        .o_bytes_pending  (bytes_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Holds start high until the encoder takes the item.
    task automatic send_number(input logic [VALUE_W-1:0] value, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 99) < 36) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            i_value <= VALUE_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // The pending count is registered, so let the last item register first.
    task automatic drain_results();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_number();
        int choice;
        int n_digits;
        int lo;
        int hi;
        int mag;
        choice = $urandom_range(0, 99);
        if (choice < 40) begin
            return VALUE_W'($urandom);
        end
        if (choice < 85) begin
            // Spread over digit counts so short encodings are as common as long ones.
            n_digits = $urandom_range(1, 5);
            lo = (n_digits == 1) ? 0 : 10 ** (n_digits - 1);
            hi = (n_digits == 5) ? 65535 : 10 ** n_digits - 1;
            mag = $urandom_range(lo, hi);
            return $urandom_range(0, 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
        end
        case ($urandom_range(0, 6))
            0:       return VALUE_MOST_NEG;
            1:       return VALUE_CLAMPED;
            2:       return 17'h0FFFF;
            3:       return 17'h1FFFF;
            4:       return 17'h00000;
            5:       return 17'h18000;
            default: return 17'h07FFF;
        endcase
    endfunction

    initial begin
        logic [VALUE_W-1:0] directed[$];
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_value = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{17'd0, 17'd1, -17'sd1, 17'd9, 17'd10, -17'sd10, 17'd99, 17'd100,
                     17'd255, 17'd256, -17'sd256, 17'd9999, 17'd10000, 17'd12345,
                     17'd32767, -17'sd32768, 17'd32768, 17'd65534, 17'd65535,
                     -17'sd65535, VALUE_MOST_NEG, -17'sd9, -17'sd54321, 17'd65535};
        foreach (directed[i]) begin
            send_number(directed[i], i > 12);
        end
        drain_results();

        for (item_idx = 0; item_idx < 350; item_idx++) begin
            if (item_idx == 120) begin
                drain_results();
            end
            // Items 150 to 249 go back to back.
            send_number(pick_number(), item_idx < 150 || item_idx >= 250);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && bytes_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sie_pkg.sv
hw/rtl/sie_digit.sv
hw/rtl/small_integer_number_encoder.sv
dv/sie_checker.sv
dv/tb_top.sv
